FILE: hw/rtl/bdte_pkg.sv
// Shared constants and helpers for the BCD date/time to epoch seconds converter.
// No dependencies; imported by the converter core.
package bdte_pkg;

	localparam int unsigned SecsPerYear = 31536000;
	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned SecsPerMin  = 60;

	// The epoch year 1970 lies thirty years before the base year 2000.
	localparam int unsigned YearsToBase = 30;
	// Leap days from 1970 through the end of year yr-1 are (yr + 31) / 4,
	// less one once 2100 has passed.
	localparam int unsigned LeapBias    = 31;
	localparam int unsigned NonLeapYear = 100;

	localparam int unsigned ResultWidth = 32;

	typedef logic [ResultWidth-1:0] word_t;

	typedef struct packed {
		logic [6:0] sec;
		logic [6:0] min;
		logic [5:0] hour;
		logic [8:0] days;
		logic [7:0] years;
	} decoded_t;

	// Two BCD digits; a digit above nine counts at its binary value.
	function automatic logic [7:0] bcd_decode(input logic [7:0] v);
		logic [7:0] hi;
		hi = {4'd0, v[7:4]};
		return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
	endfunction

	// Days in the year before the first of the month; an invalid month gets zero.
	function automatic logic [8:0] days_before(input logic [4:0] mon);
		logic [8:0] d;
		case (mon)
			5'd2:    d = 9'd31;
			5'd3:    d = 9'd59;
			5'd4:    d = 9'd90;
			5'd5:    d = 9'd120;
			5'd6:    d = 9'd151;
			5'd7:    d = 9'd181;
			5'd8:    d = 9'd212;
			5'd9:    d = 9'd243;
			5'd10:   d = 9'd273;
			5'd11:   d = 9'd304;
			5'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: hw/rtl/bcd_datetime_to_epoch_seconds.sv
// BCD real-time-clock reading to POSIX seconds, four-stage pipeline.
// Depends on bdte_pkg for constants and the BCD and month helpers.
//
// Usage: drive the six BCD fields and raise start for one cycle per reading.
// A reading is taken at each rising edge where start is high and busy is low.
// busy is always low, so a new reading may enter on every cycle.
// Each reading yields one beat on epoch_seconds, marked by done for exactly
// one cycle. The result passes through these stages:
//   stage 1 decodes the BCD digits, looks up the month offset and leap day,
//   stage 2 forms the constant products, stage 3 adds them in two groups,
//   and the output register takes the final 32-bit sum.
// Throughput is one reading per cycle.
// The receiver cannot stall; a beat that is not taken is lost to it.
// Reset clears the valid bits of every stage, so no beat follows reset
// until a new reading enters. Results are reduced modulo 2^32.
module bcd_datetime_to_epoch_seconds (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [6:0]                    seconds_bcd,
	input  logic [6:0]                    minutes_bcd,
	input  logic [5:0]                    hours_bcd,
	input  logic [5:0]                    day_bcd,
	input  logic [4:0]                    month_bcd,
	input  logic [7:0]                    year_bcd,
	output logic                          done,
	output logic [bdte_pkg::ResultWidth-1:0] epoch_seconds
);
	import bdte_pkg::*;

	logic     accept;
	decoded_t dec;
	logic [7:0] yr;
	logic [4:0] mon;
	logic       leap;
	logic [8:0] offset;
	logic [5:0] leapdays;

	logic     valid_s1, valid_s2, valid_s3;
	decoded_t data_s1;
	word_t    sec_s2, min_s2, hour_s2, day_s2, year_s2;
	word_t    big_s3, small_s3;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		yr   = bcd_decode(year_bcd);
		mon  = 5'(bcd_decode({3'd0, month_bcd}));
		// Full year 2000 + yr: only 2100 breaks the four-year rule in range.
		leap = (yr[1:0] == 2'd0) && (yr != 8'(NonLeapYear));
		offset = days_before(mon);
		if (mon > 5'd2 && mon <= 5'd12 && leap) begin
			offset = offset + 9'd1;
		end
		leapdays = 6'(({1'b0, yr} + 9'(LeapBias)) >> 2)
			- ((yr > 8'(NonLeapYear)) ? 6'd1 : 6'd0);
		dec.sec   = 7'(bcd_decode({1'b0, seconds_bcd}));
		dec.min   = 7'(bcd_decode({1'b0, minutes_bcd}));
		dec.hour  = 6'(bcd_decode({2'd0, hours_bcd}));
		// At least seven leap days lie behind any year, so this never goes negative.
		dec.days  = 9'(bcd_decode({2'd0, day_bcd})) + offset + 9'(leapdays) - 9'd1;
		dec.years = yr + 8'(YearsToBase);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= dec;

		sec_s2  <= word_t'(data_s1.sec);
		min_s2  <= word_t'(data_s1.min * 13'(SecsPerMin));
		hour_s2 <= word_t'(data_s1.hour * 18'(SecsPerHour));
		day_s2  <= word_t'(data_s1.days * 26'(SecsPerDay));
		year_s2 <= word_t'({25'd0, data_s1.years} * 33'(SecsPerYear));

		big_s3   <= day_s2 + year_s2;
		small_s3 <= sec_s2 + min_s2 + hour_s2;

		epoch_seconds <= big_s3 + small_s3;
	end

endmodule

FILE: hw/rtl/bdte_checker.sv
// Port-level checker for the BCD date/time to epoch seconds converter.
// Depends only on the top-level ports; bound to bcd_datetime_to_epoch_seconds below.
module bdte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [6:0]  seconds_bcd,
	input logic [6:0]  minutes_bcd,
	input logic [5:0]  hours_bcd,
	input logic [5:0]  day_bcd,
	input logic [4:0]  month_bcd,
	input logic [7:0]  year_bcd,
	input logic        done,
	input logic [31:0] epoch_seconds
);

	// Every accepted reading produces its result beat.
	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted reading produced no result beat");

	// No beat appears without an earlier accepted reading.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result beat without an accepted reading");

	// Two back-to-back identical readings give identical results.
	a_same_in_same_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done)
		&& $past(seconds_bcd, 4) == $past(seconds_bcd, 5)
		&& $past(minutes_bcd, 4) == $past(minutes_bcd, 5)
		&& $past(hours_bcd, 4) == $past(hours_bcd, 5)
		&& $past(day_bcd, 4) == $past(day_bcd, 5)
		&& $past(month_bcd, 4) == $past(month_bcd, 5)
		&& $past(year_bcd, 4) == $past(year_bcd, 5)
		|-> $stable(epoch_seconds))
		else $error("identical readings gave different results");

	// The converter never holds readings off.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind bcd_datetime_to_epoch_seconds bdte_checker u_bdte_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.seconds_bcd   (seconds_bcd),
	.minutes_bcd   (minutes_bcd),
	.hours_bcd     (hours_bcd),
	.day_bcd       (day_bcd),
	.month_bcd     (month_bcd),
	.year_bcd      (year_bcd),
	.done          (done),
	.epoch_seconds (epoch_seconds)
);

FILE: test/tb_bcd_datetime_to_epoch_seconds.sv
// Self-checking testbench for bcd_datetime_to_epoch_seconds: BCD clock readings in, epoch seconds out.
// Needs bdte_pkg and the converter RTL; its predictor computes each expected result independently.
`timescale 1ns / 1ps

module tb_bcd_datetime_to_epoch_seconds;

	localparam int unsigned PipeDepth      = 4;
	localparam int unsigned StallLimit     = 2000;
	localparam int unsigned ReadingsPerRun = 180;
	localparam int unsigned CumDays [12] = '{
		0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
	};

	typedef struct {
		logic [6:0]  sec_bcd;
		logic [6:0]  min_bcd;
		logic [5:0]  hour_bcd;
		logic [5:0]  day_bcd;
		logic [4:0]  month_bcd;
		logic [7:0]  year_bcd;
		bit          wait_drain;
		int unsigned idle_pct;
	} reading_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	bdte_pkg::word_t epoch_seconds;

	reading_t        driven_reading = '{default: '0};
	reading_t        pending_readings [$];
	bdte_pkg::word_t expected_epochs [$];
	bit              took_beat = 1'b0;
	int unsigned     idle_cycles = 0;
	int unsigned     error_count = 0;

	bcd_datetime_to_epoch_seconds dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.seconds_bcd   (driven_reading.sec_bcd),
		.minutes_bcd   (driven_reading.min_bcd),
		.hours_bcd     (driven_reading.hour_bcd),
		.day_bcd       (driven_reading.day_bcd),
		.month_bcd     (driven_reading.month_bcd),
		.year_bcd      (driven_reading.year_bcd),
		.done          (done),
		.epoch_seconds (epoch_seconds)
	);

	function automatic longint unsigned digit_pair(input logic [7:0] v);
		return {60'd0, v[7:4]} * 10 + {60'd0, v[3:0]};
	endfunction

	function automatic bit is_gregorian_leap(input longint unsigned year);
		if (year % 400 == 0)
			return 1'b1;
		if (year % 100 == 0)
			return 1'b0;
		return (year % 4 == 0);
	endfunction

	function automatic bdte_pkg::word_t epoch_of(input reading_t r);
		longint unsigned s, m, h, d, mo, yr, y1900, offset, leapdays, yday, total;
		s = digit_pair({1'b0, r.sec_bcd});
		m = digit_pair({1'b0, r.min_bcd});
		h = digit_pair({2'b0, r.hour_bcd});
		d = digit_pair({2'b0, r.day_bcd});
		mo = digit_pair({3'b0, r.month_bcd});
		yr = digit_pair(r.year_bcd);
		y1900 = yr + 100;
		offset = 0;
		if (mo >= 1 && mo <= 12) begin
			offset = CumDays[int'(mo - 1)];
			if (mo > 2 && is_gregorian_leap(yr + 2000))
				offset++;
		end
		// Day zero on the first month wraps below zero; the 32-bit truncation absorbs it.
		yday = d + offset - 1;
		leapdays = (y1900 - 69) / 4 - (y1900 - 1) / 100 + (y1900 + 299) / 400;
		total = s + m * 60 + h * 3600 + yday * 86400 + (y1900 - 70) * 31536000
			+ leapdays * 86400;
		return total[31:0];
	endfunction

	function automatic logic [7:0] to_bcd(input int unsigned v);
		logic [7:0] b;
		b[7:4] = 4'(v / 10);
		b[3:0] = 4'(v % 10);
		return b;
	endfunction

	function automatic reading_t make_reading(input logic [7:0] s, input logic [7:0] m,
		input logic [7:0] h, input logic [7:0] d, input logic [7:0] mo, input logic [7:0] y);
		reading_t r;
		r.sec_bcd = s[6:0];
		r.min_bcd = m[6:0];
		r.hour_bcd = h[5:0];
		r.day_bcd = d[5:0];
		r.month_bcd = mo[4:0];
		r.year_bcd = y;
		r.wait_drain = 1'b0;
		r.idle_pct = 0;
		return r;
	endfunction

	task automatic queue_reading(input reading_t r, input int unsigned idle, input bit drain);
		r.idle_pct = idle;
		r.wait_drain = drain;
		pending_readings.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: a new beat is offered at the falling edge once the previous one was taken.
	always @(negedge clk) begin
		reading_t head;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took_beat) begin
			if (pending_readings.size() == 0) begin
				start <= 1'b0;
			end else begin
				head = pending_readings[0];
				if (head.wait_drain && expected_epochs.size() != 0) begin
					start <= 1'b0;
				end else if ($urandom_range(99) < head.idle_pct) begin
					start <= 1'b0;
				end else begin
					head = pending_readings.pop_front();
					driven_reading <= head;
					start <= 1'b1;
				end
			end
		end
	end

	// Monitor and scoreboard, with a watchdog on cycles that move no beat.
	always @(posedge clk) begin
		bdte_pkg::word_t want;
		took_beat = arst_n && start && !busy;
		if (took_beat)
			expected_epochs.push_back(epoch_of(driven_reading));
		if (arst_n && done) begin
			if (expected_epochs.size() == 0) begin
				$error("epoch_seconds: result with no reading pending, got %0d", epoch_seconds);
				error_count++;
			end else begin
				want = expected_epochs.pop_front();
				if (epoch_seconds !== want) begin
					$error("epoch_seconds: expected %0d, got %0d", want, epoch_seconds);
					error_count++;
				end
			end
		end
		if (took_beat || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("tb_bcd_datetime_to_epoch_seconds: errors");
			$finish;
		end
	end

	initial begin
		int unsigned idle;
		reading_t r;

		// Directed readings: range limits, digits above nine, odd months and days, leap rules.
		queue_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00), 38, 1'b0);
		queue_reading(make_reading(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99), 38, 1'b0);
		queue_reading(make_reading(8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h1F, 8'hFF), 38, 1'b0);
		queue_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 38, 1'b0);
		queue_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00), 38, 1'b0);
		queue_reading(make_reading(8'h30, 8'h15, 8'h12, 8'h29, 8'h02, 8'h00), 38, 1'b0);
		queue_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00), 38, 1'b0);
		queue_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01), 38, 1'b0);
		queue_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h04), 38, 1'b0);
		queue_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h96), 38, 1'b0);
		queue_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h96), 38, 1'b0);
		queue_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'hA0), 38, 1'b0);
		queue_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'hC8), 38, 1'b0);
		queue_reading(make_reading(8'h01, 8'h02, 8'h03, 8'h15, 8'h13, 8'h24), 38, 1'b0);
		queue_reading(make_reading(8'h01, 8'h02, 8'h03, 8'h15, 8'h1F, 8'h24), 38, 1'b0);
		queue_reading(make_reading(8'h01, 8'h02, 8'h03, 8'h15, 8'h00, 8'h24), 38, 1'b0);
		queue_reading(make_reading(8'h01, 8'h02, 8'h03, 8'h15, 8'h0A, 8'h24), 38, 1'b0);
		queue_reading(make_reading(8'h5A, 8'h6F, 8'h2C, 8'h1B, 8'h05, 8'h9F), 38, 1'b0);
		queue_reading(make_reading(8'h59, 8'h59, 8'h23, 8'h3F, 8'h12, 8'hFF), 38, 1'b0);

		// Random readings in three runs: light sender gaps, heavy gaps, none.
		for (int run = 0; run < 3; run++) begin
			idle = (run == 0) ? 38 : (run == 1) ? 88 : 0;
			for (int unsigned i = 0; i < ReadingsPerRun; i++) begin
				if ($urandom_range(99) < 80)
					r = make_reading(to_bcd($urandom_range(59)), to_bcd($urandom_range(59)),
						to_bcd($urandom_range(23)), to_bcd($urandom_range(31, 1)),
						to_bcd($urandom_range(12, 1)), to_bcd($urandom_range(99)));
				else
					r = make_reading(8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom), 8'($urandom));
				queue_reading(r, idle, i == 0 || i == ReadingsPerRun / 2 ||
					$urandom_range(63) == 0);
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_readings.size() != 0 || start)
			@(posedge clk);
		while (expected_epochs.size() != 0)
			@(posedge clk);
		repeat (PipeDepth + 4) @(posedge clk);

		if (error_count == 0)
			$display("tb_bcd_datetime_to_epoch_seconds: clean");
		else
			$display("tb_bcd_datetime_to_epoch_seconds: errors");
		$finish;
	end

endmodule
